// File: design/framed_wind_sentence_parser_top_defines.svh
// Assertion macros used by the parser top level
`ifndef FRAMED_WIND_SENTENCE_PARSER_TOP_DEFINES_SVH
`define FRAMED_WIND_SENTENCE_PARSER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset
`define FWSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen at a clock edge out of reset
`define FWSP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define FWSP_ASSERT(lbl, prop, msg)
`define FWSP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: design/fwsp_pkg.sv
package fwsp_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned CMD_DEPTH_DEF   = 4;
  localparam int unsigned RES_DEPTH_DEF   = 2;

  // Payload length counter width (the user keeps the limit at 63 or below; not checked here)
  localparam int unsigned LEN_W = 6;

  // Control and field characters
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_F     = 8'h46;

  // Saturation limits and status letter codes
  localparam logic [9:0]  DIR_MAX   = 10'd999;
  localparam logic [16:0] SPEED_MAX = 17'd99999;
  localparam logic [6:0]  ERR_MAX   = 7'd99;
  localparam logic [6:0]  ERR_V     = 7'd11;
  localparam logic [6:0]  ERR_A     = 7'd10;

  // Field positions within the payload
  localparam logic [2:0] FLD_DEVICE = 3'd0;
  localparam logic [2:0] FLD_DIR    = 3'd1;
  localparam logic [2:0] FLD_SPEED  = 3'd2;
  localparam logic [2:0] FLD_UNIT   = 3'd3;
  localparam logic [2:0] FLD_STATUS = 3'd4;
  localparam logic [2:0] FLD_LAST   = 3'd5;

  // Unit codes
  localparam logic [2:0] UNIT_MS    = 3'd0;
  localparam logic [2:0] UNIT_KNOTS = 3'd1;
  localparam logic [2:0] UNIT_MPH   = 3'd2;
  localparam logic [2:0] UNIT_KMH   = 3'd3;
  localparam logic [2:0] UNIT_FTMIN = 3'd4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MISSING  = 3'd1,
    ST_CHECKSUM = 3'd2,
    ST_DEVICE   = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } phase_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_stx;
    logic       is_etx;
    logic       is_eol;
    logic       is_comma;
    logic       is_point;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] nibble;
  } token_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic [7:0]  device_id;
    logic [9:0]  direction;
    logic [16:0] speed_hundredths;
    logic [2:0]  unit_code;
    logic [6:0]  error_code;
    logic [7:0]  checksum_computed;
    logic [7:0]  checksum_given;
  } res_t;

endpackage

// File: design/fwsp_front.sv
module fwsp_front (
  input  logic [7:0]      rx_byte_i,
  output fwsp_pkg::token_t tok_o
);

  logic is_dec, is_lower, is_upper;

  // Character classes
  assign is_dec   = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);
  assign is_lower = (rx_byte_i >= 8'h61) && (rx_byte_i <= 8'h66);
  assign is_upper = (rx_byte_i >= 8'h41) && (rx_byte_i <= 8'h46);

  // Build the token; letters a-f have low nibble 1..6, so add 9
  always_comb begin
    tok_o.data     = rx_byte_i;
    tok_o.is_stx   = (rx_byte_i == fwsp_pkg::CH_STX);
    tok_o.is_etx   = (rx_byte_i == fwsp_pkg::CH_ETX);
    tok_o.is_eol   = (rx_byte_i == fwsp_pkg::CH_LF) || (rx_byte_i == fwsp_pkg::CH_CR);
    tok_o.is_comma = (rx_byte_i == fwsp_pkg::CH_COMMA);
    tok_o.is_point = (rx_byte_i == fwsp_pkg::CH_POINT);
    tok_o.is_digit = is_dec;
    tok_o.is_hex   = is_dec || is_lower || is_upper;
    if (is_dec) begin
      tok_o.nibble = rx_byte_i[3:0];
    end else begin
      tok_o.nibble = 4'(rx_byte_i[3:0] + 4'd9);
    end
  end

endmodule

// File: design/fwsp_queue.sv
module fwsp_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/fwsp_back.sv
module fwsp_back #(
  parameter int unsigned MAX_PAYLOAD = fwsp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fwsp_pkg::token_t tok_i,
  input  logic             tok_valid_i,
  output logic             tok_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output fwsp_pkg::res_t   res_o
);

  fwsp_pkg::phase_e phase_q, phase_d;
  logic [7:0]             xor_q, xor_d;
  logic [2:0]             fidx_q, fidx_d;
  logic [fwsp_pkg::LEN_W-1:0] len_q, len_d;
  logic                   nonempty_q, nonempty_d;
  logic                   halted_q, halted_d;
  logic [7:0]             dev_q, dev_d;
  logic [9:0]             dir_q, dir_d;
  logic [16:0]            spd_q, spd_d;
  logic [1:0]             frac_q, frac_d;
  logic                   point_q, point_d;
  logic [7:0]             unit_q, unit_d;
  logic [6:0]             err_q, err_d;
  logic [7:0]             ck_q, ck_d;

  logic        step;
  logic        first;
  logic        emit;
  logic [13:0] dir_x;
  logic [19:0] spd_x;
  logic [9:0]  err_x;
  logic [2:0]  unit_code;
  fwsp_pkg::status_e frame_st;

  assign step      = tok_valid_i && !res_full_i;
  assign tok_pop_o = step;
  assign first     = !nonempty_q;

  // A result leaves only with a token actually taken
  assign res_push_o = emit && step;

  // Decimal accumulate candidates
  assign dir_x = 14'(dir_q) * 14'd10 + 14'(tok_i.nibble);
  assign err_x = 10'(err_q) * 10'd10 + 10'(tok_i.nibble);
  always_comb begin
    if (!point_q) begin
      spd_x = 20'(spd_q) * 20'd10 + 20'(tok_i.nibble) * 20'd100;
    end else if (frac_q == 2'd0) begin
      spd_x = 20'(spd_q) + 20'(tok_i.nibble) * 20'd10;
    end else if (frac_q == 2'd1) begin
      spd_x = 20'(spd_q) + 20'(tok_i.nibble);
    end else begin
      spd_x = 20'(spd_q);
    end
  end

  // Unit letter map and frame status
  always_comb begin
    case (unit_q)
      fwsp_pkg::CH_N: unit_code = fwsp_pkg::UNIT_KNOTS;
      fwsp_pkg::CH_P: unit_code = fwsp_pkg::UNIT_MPH;
      fwsp_pkg::CH_K: unit_code = fwsp_pkg::UNIT_KMH;
      fwsp_pkg::CH_F: unit_code = fwsp_pkg::UNIT_FTMIN;
      default:        unit_code = fwsp_pkg::UNIT_MS;
    endcase
    if (xor_q != ck_q) begin
      frame_st = fwsp_pkg::ST_CHECKSUM;
    end else if (err_q != '0) begin
      frame_st = fwsp_pkg::ST_DEVICE;
    end else begin
      frame_st = fwsp_pkg::ST_OK;
    end
  end

  // Parse step for one token
  always_comb begin
    phase_d    = phase_q;
    xor_d      = xor_q;
    fidx_d     = fidx_q;
    len_d      = len_q;
    nonempty_d = nonempty_q;
    halted_d   = halted_q;
    dev_d      = dev_q;
    dir_d      = dir_q;
    spd_d      = spd_q;
    frac_d     = frac_q;
    point_d    = point_q;
    unit_d     = unit_q;
    err_d      = err_q;
    ck_d       = ck_q;
    emit       = 1'b0;
    res_o      = '0;

    if (phase_q == fwsp_pkg::PH_CHECK) begin
      if (tok_i.is_hex) begin
        ck_d = {ck_q[3:0], tok_i.nibble};
      end else begin
        emit                    = 1'b1;
        res_o.status            = frame_st;
        res_o.device_id         = dev_q;
        res_o.direction         = dir_q;
        res_o.speed_hundredths  = spd_q;
        res_o.unit_code         = unit_code;
        res_o.error_code        = err_q;
        res_o.checksum_computed = xor_q;
        res_o.checksum_given    = ck_q;
        phase_d                 = fwsp_pkg::PH_IDLE;
      end
    end

    if (tok_i.is_stx) begin
      // A start byte always opens a clean frame
      phase_d    = fwsp_pkg::PH_PAYLOAD;
      xor_d      = '0;
      fidx_d     = '0;
      len_d      = '0;
      nonempty_d = 1'b0;
      halted_d   = 1'b0;
      dev_d      = '0;
      dir_d      = '0;
      spd_d      = '0;
      frac_d     = '0;
      point_d    = 1'b0;
      unit_d     = '0;
      err_d      = '0;
      ck_d       = '0;
    end else if (phase_q == fwsp_pkg::PH_PAYLOAD) begin
      if (tok_i.is_etx) begin
        phase_d = fwsp_pkg::PH_CHECK;
        ck_d    = '0;
      end else if (tok_i.is_eol) begin
        emit                    = 1'b1;
        res_o.status            = fwsp_pkg::ST_MISSING;
        res_o.checksum_computed = xor_q;
        phase_d                 = fwsp_pkg::PH_IDLE;
      end else if (len_q >= fwsp_pkg::LEN_W'(MAX_PAYLOAD)) begin
        emit                    = 1'b1;
        res_o.status            = fwsp_pkg::ST_TOO_LONG;
        res_o.checksum_computed = xor_q;
        phase_d                 = fwsp_pkg::PH_IDLE;
      end else begin
        len_d = fwsp_pkg::LEN_W'(len_q + 1'b1);
        xor_d = xor_q ^ tok_i.data;
        if (tok_i.is_comma) begin
          // Runs of separators count once
          if (nonempty_q) begin
            if (fidx_q < fwsp_pkg::FLD_LAST) begin
              fidx_d = 3'(fidx_q + 1'b1);
            end
            nonempty_d = 1'b0;
            halted_d   = 1'b0;
            point_d    = 1'b0;
          end
        end else begin
          nonempty_d = 1'b1;
          case (fidx_q)
            fwsp_pkg::FLD_DEVICE: begin
              if (first) dev_d = tok_i.data;
            end
            fwsp_pkg::FLD_DIR: begin
              if (!halted_q) begin
                if (!tok_i.is_digit) begin
                  halted_d = 1'b1;
                end else begin
                  dir_d = (dir_x > 14'(fwsp_pkg::DIR_MAX)) ?
                          fwsp_pkg::DIR_MAX : dir_x[9:0];
                end
              end
            end
            fwsp_pkg::FLD_SPEED: begin
              if (!halted_q) begin
                if (tok_i.is_point && !point_q) begin
                  point_d = 1'b1;
                end else if (!tok_i.is_digit) begin
                  halted_d = 1'b1;
                end else begin
                  if (point_q && frac_q == 2'd0) frac_d = 2'd1;
                  else if (point_q && frac_q == 2'd1) frac_d = 2'd2;
                  spd_d = (spd_x > 20'(fwsp_pkg::SPEED_MAX)) ?
                          fwsp_pkg::SPEED_MAX : spd_x[16:0];
                end
              end
            end
            fwsp_pkg::FLD_UNIT: begin
              if (first) unit_d = tok_i.data;
            end
            fwsp_pkg::FLD_STATUS: begin
              // point flag marks a token that is so far a lone V or A
              if (first && (tok_i.data == fwsp_pkg::CH_V ||
                            tok_i.data == fwsp_pkg::CH_A)) begin
                err_d    = (tok_i.data == fwsp_pkg::CH_V) ?
                           fwsp_pkg::ERR_V : fwsp_pkg::ERR_A;
                point_d  = 1'b1;
                halted_d = 1'b1;
              end else if (point_q) begin
                err_d   = '0;
                point_d = 1'b0;
              end else if (!halted_q) begin
                if (!tok_i.is_digit) begin
                  halted_d = 1'b1;
                end else begin
                  err_d = (err_x > 10'(fwsp_pkg::ERR_MAX)) ?
                          fwsp_pkg::ERR_MAX : err_x[6:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end else if (phase_q != fwsp_pkg::PH_CHECK && phase_q != fwsp_pkg::PH_IDLE) begin
      phase_d = fwsp_pkg::PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fwsp_pkg::PH_IDLE;
      xor_q      <= '0;
      fidx_q     <= '0;
      len_q      <= '0;
      nonempty_q <= 1'b0;
      halted_q   <= 1'b0;
      dev_q      <= '0;
      dir_q      <= '0;
      spd_q      <= '0;
      frac_q     <= '0;
      point_q    <= 1'b0;
      unit_q     <= '0;
      err_q      <= '0;
      ck_q       <= '0;
    end else if (step) begin
      phase_q    <= phase_d;
      xor_q      <= xor_d;
      fidx_q     <= fidx_d;
      len_q      <= len_d;
      nonempty_q <= nonempty_d;
      halted_q   <= halted_d;
      dev_q      <= dev_d;
      dir_q      <= dir_d;
      spd_q      <= spd_d;
      frac_q     <= frac_d;
      point_q    <= point_d;
      unit_q     <= unit_d;
      err_q      <= err_d;
      ck_q       <= ck_d;
    end
  end

endmodule

// File: design/framed_wind_sentence_parser_top.sv
// Framed wind sentence parser.
// Input channel: one received byte per transfer on rx_byte_i, taken at a clock
// edge with push high and full low. Output channel: one parsed frame result
// on the result ports while empty is low, removed at an edge with pop high.
// Bytes go through a classifier into a short command queue; the parser takes
// one queued byte per cycle while the result queue is not full, and writes
// any result into a result queue. Throughput: one byte per clock cycle.
// With both queues drained, the byte that closes the frame (first non-hex
// byte after the checksum, a line end in the payload, or the byte past the
// length limit) is registered in the command queue, parsed from its head and
// its result registered in the result queue, whose head drives the outputs.
// When the receiver stalls, the result queue fills, the parser stops taking
// bytes, and full rises once the command queue is full as well; nothing is
// lost. Reset empties both queues and leaves the parser waiting for a start
// byte with all fields cleared; no clearing pass is needed.
`include "framed_wind_sentence_parser_top_defines.svh"

module framed_wind_sentence_parser_top #(
  parameter int unsigned MAX_PAYLOAD = fwsp_pkg::MAX_PAYLOAD_DEF,
  parameter int unsigned CMD_DEPTH   = fwsp_pkg::CMD_DEPTH_DEF,
  parameter int unsigned RES_DEPTH   = fwsp_pkg::RES_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [7:0]  device_id_o,
  output logic [9:0]  direction_o,
  output logic [16:0] speed_hundredths_o,
  output logic [2:0]  unit_code_o,
  output logic [6:0]  error_code_o,
  output logic [7:0]  checksum_computed_o,
  output logic [7:0]  checksum_given_o
);

  fwsp_pkg::token_t tok_in, tok_head;
  fwsp_pkg::res_t   res_new, res_head;
  logic cmd_empty, cmd_full, cmd_pop;
  logic res_full, res_push;

  // Classifier
  fwsp_front u_front (
    .rx_byte_i (rx_byte_i),
    .tok_o     (tok_in)
  );

  // Front to back decoupling queue
  fwsp_queue #(
    .T     (fwsp_pkg::token_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .pop_i   (cmd_pop),
    .data_o  (tok_head),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  assign full = cmd_full;

  // Frame parser
  fwsp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_head),
    .tok_valid_i (!cmd_empty),
    .tok_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  // Result queue
  fwsp_queue #(
    .T     (fwsp_pkg::res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty),
    .full_o  (res_full)
  );

  assign status_o            = res_head.status;
  assign device_id_o         = res_head.device_id;
  assign direction_o         = res_head.direction;
  assign speed_hundredths_o  = res_head.speed_hundredths;
  assign unit_code_o         = res_head.unit_code;
  assign error_code_o        = res_head.error_code;
  assign checksum_computed_o = res_head.checksum_computed;
  assign checksum_given_o    = res_head.checksum_given;

  // Checks
  `FWSP_ASSERT(a_res_no_overrun, res_push |-> !res_full,
    "result written into a full queue")
  `FWSP_ASSERT(a_cmd_no_underrun, cmd_pop |-> !cmd_empty,
    "parser took a byte from an empty queue")
  `FWSP_ASSERT(a_ok_sum_match,
    (!empty && status_o == fwsp_pkg::ST_OK) |->
    (checksum_computed_o == checksum_given_o),
    "ok status with differing checksums")
  `FWSP_ASSERT(a_err_fields_zero,
    (!empty && (status_o == fwsp_pkg::ST_MISSING || status_o == fwsp_pkg::ST_TOO_LONG)) |->
    (device_id_o == '0 && direction_o == '0 && error_code_o == '0 &&
     checksum_given_o == '0),
    "aborted frame carries field data")

endmodule

// File: verif/tb.sv
module tb;
  import fwsp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1530;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;

  // Expectations that can be read straight off the frame text
  localparam res_t EMPTY_LINE_END = '{ST_MISSING, 8'h00, 10'd0, 17'd0, UNIT_MS, 7'd0,
                                      8'h00, 8'h00};
  localparam res_t EMPTY_FRAME_OK = '{ST_OK, 8'h00, 10'd0, 17'd0, UNIT_MS, 7'd0,
                                      8'h00, 8'h00};
  // An even run of identical bytes cancels in the XOR
  localparam res_t OVERLONG_EVEN  = '{ST_TOO_LONG, 8'h00, 10'd0, 17'd0, UNIT_MS, 7'd0,
                                      8'h00, 8'h00};

  typedef struct {
    string text;
    bit    fixed;
    res_t  want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  device_id_o;
  logic [9:0]  direction_o;
  logic [16:0] speed_hundredths_o;
  logic [2:0]  unit_code_o;
  logic [6:0]  error_code_o;
  logic [7:0]  checksum_computed_o;
  logic [7:0]  checksum_given_o;

  // Frame tracker state
  phase_e      frame_ph;
  logic [7:0]  body_xor;
  logic [2:0]  field_no;
  int unsigned body_len;
  bit          field_open;
  bit          num_stopped;
  logic [7:0]  dev_char;
  logic [9:0]  dir_val;
  logic [16:0] speed_val;
  logic [1:0]  frac_cnt;
  bit          mark_seen;   // decimal point in the speed, lone letter in the status
  logic [7:0]  unit_char;
  logic [6:0]  err_val;
  logic [7:0]  sum_given;

  res_t        expected_frames[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  tx_bytes[$];
  logic [7:0]  tx_sum;

  int unsigned idle_pct = 11;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_bytes = 0;
  int unsigned frame_bytes = 0;
  int unsigned frames_checked = 0;
  int unsigned status_count[5] = '{default: 0};

  framed_wind_sentence_parser_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .rx_byte_i          (rx_byte_i),
    .empty              (empty),
    .pop                (pop),
    .status_o           (status_o),
    .device_id_o        (device_id_o),
    .direction_o        (direction_o),
    .speed_hundredths_o (speed_hundredths_o),
    .unit_code_o        (unit_code_o),
    .error_code_o       (error_code_o),
    .checksum_computed_o(checksum_computed_o),
    .checksum_given_o   (checksum_given_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Hex digit with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
  endfunction

  // Byte from 0x21 up that is never a separator or a frame control character
  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 33)); while (c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] body_byte();
    case ($urandom_range(3))
      0: return CH_COMMA;
      1: return 8'("0" + $urandom_range(9));
      default: return text_byte();
    endcase
  endfunction

  task automatic clear_frame();
    body_xor    = '0;
    field_no    = FLD_DEVICE;
    body_len    = 0;
    field_open  = 1'b0;
    num_stopped = 1'b0;
    dev_char    = '0;
    dir_val     = '0;
    speed_val   = '0;
    frac_cnt    = '0;
    mark_seen   = 1'b0;
    unit_char   = '0;
    err_val     = '0;
    sum_given   = '0;
  endtask

  // Advance the frame tracker by one byte; flags a completed frame result
  task automatic track_byte(input logic [7:0] b, output bit produced, output res_t r);
    logic [3:0]  nib;
    int unsigned v;
    int unsigned d;
    bit          first;
    bit          is_digit;
    produced = 1'b0;
    r = '0;
    if (frame_ph != PH_IDLE || b == CH_STX) frame_bytes++;

    // Checksum digits after ETX; any other byte closes the frame
    if (frame_ph == PH_CHECK) begin
      if (is_hex_char(b)) begin
        if (b <= "9") nib = 4'(b - "0");
        else if (b >= "a") nib = 4'(b - "a" + 10);
        else nib = 4'(b - "A" + 10);
        sum_given = {sum_given[3:0], nib};
        return;
      end
      produced = 1'b1;
      r.status = (body_xor != sum_given) ? ST_CHECKSUM :
                 (err_val != 0)          ? ST_DEVICE   : ST_OK;
      r.device_id        = dev_char;
      r.direction        = dir_val;
      r.speed_hundredths = speed_val;
      case (unit_char)
        CH_N:    r.unit_code = UNIT_KNOTS;
        CH_P:    r.unit_code = UNIT_MPH;
        CH_K:    r.unit_code = UNIT_KMH;
        CH_F:    r.unit_code = UNIT_FTMIN;
        default: r.unit_code = UNIT_MS;
      endcase
      r.error_code        = err_val;
      r.checksum_computed = body_xor;
      r.checksum_given    = sum_given;
      frame_ph = PH_IDLE;
      if (b == CH_STX) begin
        clear_frame();
        frame_ph = PH_PAYLOAD;
      end
      return;
    end

    if (b == CH_STX) begin
      clear_frame();
      frame_ph = PH_PAYLOAD;
      return;
    end
    if (frame_ph != PH_PAYLOAD) return;

    if (b == CH_ETX) begin
      frame_ph  = PH_CHECK;
      sum_given = '0;
      return;
    end
    // Line end or overrun abandons the frame with only the XOR reported
    if (b == CH_LF || b == CH_CR || body_len >= MAX_PAYLOAD_DEF) begin
      produced = 1'b1;
      r.status = (b == CH_LF || b == CH_CR) ? ST_MISSING : ST_TOO_LONG;
      r.checksum_computed = body_xor;
      frame_ph = PH_IDLE;
      return;
    end
    body_len++;
    body_xor ^= b;

    // Runs of commas count as one separator
    if (b == CH_COMMA) begin
      if (field_open) begin
        if (field_no < FLD_LAST) field_no++;
        field_open  = 1'b0;
        num_stopped = 1'b0;
        mark_seen   = 1'b0;
      end
      return;
    end

    first      = !field_open;
    is_digit   = (b >= "0" && b <= "9");
    d          = b - "0";
    field_open = 1'b1;
    case (field_no)
      FLD_DEVICE: if (first) dev_char = b;
      FLD_DIR: begin
        if (!num_stopped) begin
          if (!is_digit) begin
            num_stopped = 1'b1;
          end else begin
            v = dir_val * 10 + d;
            dir_val = (v > DIR_MAX) ? DIR_MAX : v[9:0];
          end
        end
      end
      FLD_SPEED: begin
        if (!num_stopped) begin
          if (b == CH_POINT && !mark_seen) begin
            mark_seen = 1'b1;
          end else if (!is_digit) begin
            num_stopped = 1'b1;
          end else begin
            // Two fraction digits kept, the rest truncated
            if (!mark_seen) begin
              v = speed_val * 10 + d * 100;
            end else if (frac_cnt == 0) begin
              v = speed_val + d * 10;
              frac_cnt = 1;
            end else if (frac_cnt == 1) begin
              v = speed_val + d;
              frac_cnt = 2;
            end else begin
              v = speed_val;
            end
            speed_val = (v > SPEED_MAX) ? SPEED_MAX : v[16:0];
          end
        end
      end
      FLD_UNIT: if (first) unit_char = b;
      FLD_STATUS: begin
        if (first && (b == CH_V || b == CH_A)) begin
          err_val     = (b == CH_V) ? ERR_V : ERR_A;
          mark_seen   = 1'b1;
          num_stopped = 1'b1;
        end else if (mark_seen) begin
          // Letter followed by anything is no longer a status letter
          err_val   = '0;
          mark_seen = 1'b0;
        end else if (!num_stopped) begin
          if (!is_digit) begin
            num_stopped = 1'b1;
          end else begin
            v = err_val * 10 + d;
            err_val = (v > ERR_MAX) ? ERR_MAX : v[6:0];
          end
        end
      end
      default: ;
    endcase
  endtask

  // One input transfer, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input bit use_fixed, input res_t fixed_res);
    bit   produced;
    res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_bytes++;
    track_byte(b, produced, predicted);
    if (produced) expected_frames.push_back(use_fixed ? fixed_res : predicted);
  endtask

  task automatic put_body(input logic [7:0] b);
    tx_bytes.push_back(b);
    tx_sum ^= b;
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) put_body(8'("0" + $urandom_range(9)));
  endtask

  task automatic put_sep();
    put_body(CH_COMMA);
    if ($urandom_range(7) == 0) repeat ($urandom_range(2, 1)) put_body(CH_COMMA);
  endtask

  // Framed sentence with random field content, checksum and closing byte
  task automatic build_frame();
    int unsigned n;
    logic [7:0]  c;
    tx_bytes.delete();
    tx_sum = '0;
    tx_bytes.push_back(CH_STX);
    if ($urandom_range(9) == 0) put_body(CH_COMMA);
    // device id
    if ($urandom_range(11) != 0) put_body(text_byte());
    if ($urandom_range(5) == 0) put_body(text_byte());
    put_sep();
    // direction, sometimes with a sign, a space or a trailing junk byte
    case ($urandom_range(9))
      0: put_body("-");
      1: put_body(" ");
      default: ;
    endcase
    put_digits($urandom_range(4));
    if ($urandom_range(7) == 0) put_body(text_byte());
    put_sep();
    // speed
    put_digits($urandom_range(6));
    if ($urandom_range(2) != 0) begin
      put_body(CH_POINT);
      put_digits($urandom_range(4));
    end
    if ($urandom_range(9) == 0) put_body(CH_POINT);
    put_sep();
    // unit letter
    case ($urandom_range(6))
      0: put_body("M");
      1: put_body(CH_N);
      2: put_body(CH_P);
      3: put_body(CH_K);
      4: put_body(CH_F);
      5: put_body(text_byte());
      default: ;
    endcase
    put_sep();
    // device status
    case ($urandom_range(7))
      0: put_body(CH_V);
      1: put_body(CH_A);
      2: begin
        put_body($urandom_range(1) ? CH_V : CH_A);
        put_body(text_byte());
      end
      3: put_body("0");
      4, 5: put_digits($urandom_range(3, 1));
      6: begin
        put_digits(1);
        put_body(text_byte());
        put_digits(1);
      end
      default: ;
    endcase
    if ($urandom_range(7) == 0) begin
      put_sep();
      put_body(text_byte());
    end
    tx_bytes.push_back(CH_ETX);
    // checksum digits: mostly right, sometimes absent, wrong or over-long
    n = $urandom_range(19);
    if (n == 1) begin
      c = 8'($urandom_range(255));
      tx_bytes.push_back(hex_char(c[7:4]));
      tx_bytes.push_back(hex_char(c[3:0]));
    end else if (n != 0) begin
      if (n == 2) repeat ($urandom_range(3, 1)) tx_bytes.push_back(hex_char(4'($urandom_range(15))));
      tx_bytes.push_back(hex_char(tx_sum[7:4]));
      tx_bytes.push_back(hex_char(tx_sum[3:0]));
    end
    // closing byte
    case ($urandom_range(4))
      0: tx_bytes.push_back(CH_LF);
      1: tx_bytes.push_back(CH_STX);
      2: begin
        do c = 8'($urandom_range(255)); while (is_hex_char(c));
        tx_bytes.push_back(c);
      end
      default: tx_bytes.push_back(CH_CR);
    endcase
  endtask

  // Result checking and receiver stalls
  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          $error("frame result transfer with nothing expected (status %0d)", status_o);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          cmp_field("status", want.status, status_o);
          cmp_field("device_id", want.device_id, device_id_o);
          cmp_field("direction", want.direction, direction_o);
          cmp_field("speed_hundredths", want.speed_hundredths, speed_hundredths_o);
          cmp_field("unit_code", want.unit_code, unit_code_o);
          cmp_field("error_code", want.error_code, error_code_o);
          cmp_field("checksum_computed", want.checksum_computed, checksum_computed_o);
          cmp_field("checksum_given", want.checksum_given, checksum_given_o);
          frames_checked++;
          status_count[want.status]++;
        end
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL framed_wind_sentence_parser_top");
      $finish;
    end
  end

  initial begin
    string       long_text;
    logic [7:0]  c;
    logic [7:0]  row_sum;
    bit          body_on;
    int unsigned random_start;
    int unsigned pick;

    frame_ph = PH_IDLE;
    clear_frame();

    // Directed sentences; '*' stands for the correct checksum of the frame
    long_text = "\002";
    repeat (MAX_PAYLOAD_DEF + 1) long_text = {long_text, "x"};
    directed_rows.push_back('{"\377\003\002\n", 1'b1, EMPTY_LINE_END});
    directed_rows.push_back('{"\002\003\015", 1'b1, EMPTY_FRAME_OK});
    directed_rows.push_back('{long_text, 1'b1, OVERLONG_EVEN});
    directed_rows.push_back('{"\002W,359,12.345,K,A\003*\015", 1'b0, '0});
    directed_rows.push_back('{",Q,,999999,99999.999,F,V,x", 1'b0, '0});
    directed_rows.push_back('{"\002,Q,,999999,99999.999,F,V,x\003*\n", 1'b0, '0});
    directed_rows.push_back('{"\002M,0,0,M,0\003FF\015", 1'b0, '0});
    directed_rows.push_back('{"\002+,-12,  3.4, N,VA\003*\015", 1'b0, '0});
    directed_rows.push_back('{"\002a,7,1.2.3,P,42\003*x", 1'b0, '0});
    directed_rows.push_back('{"\002b,1,2,M,0\003abc1*\002c,5,6,N,7\003*\015", 1'b0, '0});
    directed_rows.push_back('{"\002junk,1\002d,2,3,K,0\003*\n", 1'b0, '0});
    directed_rows.push_back('{"\002e,12,3\015", 1'b0, '0});
    directed_rows.push_back('{"\002f,1\003\015", 1'b0, '0});
    directed_rows.push_back('{"\002g,1,1,M,A5\003*\015", 1'b0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 1'b0, '0);
    foreach (directed_rows[r]) begin
      body_on = 1'b0;
      row_sum = '0;
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        c = directed_rows[r].text[i];
        if (c == "*") begin
          send_byte(hex_char(row_sum[7:4]), directed_rows[r].fixed, directed_rows[r].want);
          send_byte(hex_char(row_sum[3:0]), directed_rows[r].fixed, directed_rows[r].want);
        end else begin
          if (c == CH_STX) begin
            body_on = 1'b1;
            row_sum = '0;
          end else if (c == CH_ETX) begin
            body_on = 1'b0;
          end else if (body_on) begin
            row_sum ^= c;
          end
          send_byte(c, directed_rows[r].fixed, directed_rows[r].want);
        end
      end
    end

    // Random sentences with some noise, cut-off and overrun frames mixed in
    random_start = sent_bytes;
    while (sent_bytes - random_start < RANDOM_BYTES) begin
      idle_pct = (sent_bytes - random_start >= 600 && sent_bytes - random_start < 950)
                 ? 0 : 11;
      pick = $urandom_range(99);
      if (pick < 75) begin
        build_frame();
      end else begin
        tx_bytes.delete();
        if (pick < 82) begin
          repeat ($urandom_range(6, 1)) tx_bytes.push_back(8'($urandom_range(255)));
        end else begin
          tx_bytes.push_back(CH_STX);
          if (pick < 89) begin
            repeat ($urandom_range(10)) tx_bytes.push_back(body_byte());
            tx_bytes.push_back(pick[0] ? CH_CR : CH_LF);
          end else if (pick < 94) begin
            repeat (MAX_PAYLOAD_DEF + $urandom_range(6, 1)) tx_bytes.push_back(body_byte());
          end else begin
            repeat ($urandom_range(8, 1)) tx_bytes.push_back(body_byte());
          end
        end
      end
      foreach (tx_bytes[i]) send_byte(tx_bytes[i], 1'b0, '0);
    end
    push <= 1'b0;

    // Drain outstanding results, then allow for the pipeline latency
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Drove %0d bytes (%0d inside frames), checked %0d frame results.",
             sent_bytes, frame_bytes, frames_checked);
    $display("By status: %0d ok, %0d line end, %0d checksum, %0d device, %0d overlong.",
             status_count[ST_OK], status_count[ST_MISSING], status_count[ST_CHECKSUM],
             status_count[ST_DEVICE], status_count[ST_TOO_LONG]);
    if (fail_count == 0) begin
      $display("PASS framed_wind_sentence_parser_top");
    end else begin
      $display("FAIL framed_wind_sentence_parser_top");
    end
    $finish;
  end

endmodule
